[sv/bfp_pkg.sv]
// Shared types and constants of the MSB-first bit field packer.
// No dependencies; the front, queue, back and top files import this package.
package bfp_pkg;

	// Operation codes of an input beat
	localparam logic [1:0] OP_PLAIN = 2'd0;
	localparam logic [1:0] OP_SEG   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam int WIDTH_W = 7;   // width field of an input beat
	localparam int SEG_W   = 6;   // segment_size register
	localparam int CHUNK_W = 64;  // widest chunk: full value or flag plus 63 payload bits
	localparam int ACC_W   = CHUNK_W + 8;  // up to 7 pending bits plus one chunk
	localparam int CNT_W   = 7;   // bit count in the accumulator, 0..71

	localparam logic [SEG_W-1:0] SEG_RESET = 6'd7;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SEG_SIZE = 1'b0;

	typedef enum logic [1:0] {
		CMD_PLAIN,
		CMD_SEG,
		CMD_FLUSH
	} cmd_kind_t;

	// Classified item. For plain writes the value is already top-aligned.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [CHUNK_W-1:0]    value;
		logic [WIDTH_W-1:0]    width;
		logic [SEG_W-1:0]      seg;
	} cmd_t;

endpackage

[sv/bfp_in_if.sv]
// Input channel of the bit field packer: one field write or flush per beat.
// Depends on nothing; the value width is an interface parameter.
interface bfp_in_if #(
	parameter int VALUE_WIDTH = 64
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             operation;
	logic [VALUE_WIDTH-1:0] value;
	logic [6:0]             width;

	modport source (output valid, output operation, output value, output width, input ready);
	modport sink (input valid, input operation, input value, input width, output ready);
endinterface

[sv/bfp_out_if.sv]
// Output channel of the bit field packer: one stream byte per beat.
// Depends on nothing.
interface bfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[sv/bfp_front.sv]
// Front end: accepts input beats, saturates and masks them, drops no-ops
// and writes one command per useful beat into the queue. Uses bfp_pkg.
module bfp_front #(
	parameter int VALUE_WIDTH = 64
) (
	bfp_in_if.sink                      items,
	input  logic [bfp_pkg::SEG_W-1:0]   seg_size,
	input  logic                        q_full,
	output logic                        q_push,
	output bfp_pkg::cmd_t               q_wdata
);
	import bfp_pkg::*;

	localparam logic [WIDTH_W-1:0] VW = WIDTH_W'(VALUE_WIDTH);

	logic [WIDTH_W-1:0] w_sat;
	logic [CHUNK_W-1:0] mask;
	logic [CHUNK_W-1:0] v_m;
	logic               keep;

	assign items.ready = !q_full;

	always_comb begin
		w_sat = (items.width > VW) ? VW : items.width;
		// width 64 needs an all-ones mask; the shift would overflow
		mask  = w_sat[WIDTH_W-1] ? '1 : ((CHUNK_W'(1) << w_sat[WIDTH_W-2:0]) - CHUNK_W'(1));
		v_m   = CHUNK_W'(items.value) & mask;

		q_wdata       = '0;
		q_wdata.width = w_sat;
		q_wdata.seg   = (seg_size == '0) ? SEG_W'(1) : seg_size;
		keep          = 1'b0;
		unique case (items.operation)
			OP_PLAIN: begin
				q_wdata.kind  = CMD_PLAIN;
				q_wdata.value = v_m << (WIDTH_W'(CHUNK_W) - w_sat);
				keep          = (w_sat != '0);
			end
			OP_SEG: begin
				q_wdata.kind  = CMD_SEG;
				q_wdata.value = v_m;
				keep          = (w_sat != '0);
			end
			OP_FLUSH: begin
				q_wdata.kind  = CMD_FLUSH;
				q_wdata.width = '0;
				keep          = 1'b1;
			end
			default: begin
				q_wdata.kind = CMD_FLUSH;
				keep         = 1'b0;
			end
		endcase
	end

	assign q_push = items.valid && !q_full && keep;

endmodule

[sv/bfp_queue.sv]
// Short command queue that decouples the front end from the byte engine.
// Uses bfp_pkg for the command type and depth.
module bfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bfp_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          vld,
	output bfp_pkg::cmd_t rdata
);
	import bfp_pkg::*;

	localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W = $clog2(Q_DEPTH + 1);
	localparam logic [QA_W-1:0] LAST_PTR = QA_W'(Q_DEPTH - 1);
	localparam logic [QC_W-1:0] FULL_CNT = QC_W'(Q_DEPTH);

	cmd_t            entry_q [Q_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign vld   = (count_q != '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QA_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QA_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QC_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QC_W'(1);
			end
		end
	end

endmodule

[sv/bfp_back.sv]
// Byte engine: cuts a command into chunks, merges them into the bit
// accumulator and drains full bytes one per cycle while the output takes them. Uses bfp_pkg.
module bfp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_vld,
	input  bfp_pkg::cmd_t q_rdata,
	output logic          q_pop,
	bfp_out_if.source     results
);
	import bfp_pkg::*;

	localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);

	logic               busy_q;
	cmd_kind_t          kind_q;
	logic [CHUNK_W-1:0] rem_v_q;
	logic [WIDTH_W-1:0] rem_w_q;
	logic [SEG_W-1:0]   seg_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [CNT_W-1:0]   chunk_n_q;
	logic               chunk_vld_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [7:0]         hold_q;
	logic               hold_vld_q;
	logic               out_vld_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic               out_free;
	logic               has_byte;
	logic               start;
	logic               emit;
	logic               take;
	logic               gen;
	logic               finish;
	logic               push_out;

	logic [CHUNK_W-1:0] seg_one;
	logic [CHUNK_W-1:0] payload;
	logic               more;
	logic [CHUNK_W-1:0] chunk_d;
	logic [CNT_W-1:0]   chunk_n_d;
	logic [WIDTH_W-1:0] rem_w_d;
	logic [CHUNK_W-1:0] rem_v_d;
	logic [ACC_W-1:0]   merged;

	assign out_free = !out_vld_q || results.ready;
	assign has_byte = (cnt_q >= BYTE_BITS);
	assign start    = !busy_q && q_vld;
	assign q_pop    = start;
	// the held byte goes out as last only once the item has no more bits
	assign emit     = busy_q && has_byte && (!hold_vld_q || out_free);
	assign take     = busy_q && !has_byte && chunk_vld_q;
	assign gen      = busy_q && (rem_w_q != '0) && (!chunk_vld_q || take);
	assign finish   = busy_q && !has_byte && !chunk_vld_q && (rem_w_q == '0)
		&& (!hold_vld_q || out_free);
	assign push_out = hold_vld_q && (emit || finish);

	// next chunk: whole plain field, or one flagged segment from the low end
	always_comb begin
		seg_one = CHUNK_W'(1) << seg_q;
		more    = (rem_w_q > WIDTH_W'(seg_q));
		payload = rem_v_q & (seg_one - CHUNK_W'(1));
		if (kind_q == CMD_SEG) begin
			chunk_d   = (payload | (more ? seg_one : '0)) << (SEG_W'(CHUNK_W - 1) - seg_q);
			chunk_n_d = CNT_W'(seg_q) + CNT_W'(1);
			rem_w_d   = more ? (rem_w_q - WIDTH_W'(seg_q)) : '0;
			rem_v_d   = rem_v_q >> seg_q;
		end else begin
			chunk_d   = rem_v_q;
			chunk_n_d = CNT_W'(rem_w_q);
			rem_w_d   = '0;
			rem_v_d   = rem_v_q;
		end
		merged = acc_q | ({chunk_q, 8'b0} >> cnt_q[2:0]);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_v_q <= q_rdata.value;
			seg_q   <= q_rdata.seg;
			kind_q  <= q_rdata.kind;
		end else if (gen) begin
			rem_v_q <= rem_v_d;
		end
		if (gen) begin
			chunk_q   <= chunk_d;
			chunk_n_q <= chunk_n_d;
		end
		if (emit) begin
			hold_q <= acc_q[ACC_W-1 -: 8];
		end
		if (push_out) begin
			out_byte_q <= hold_q;
			out_last_q <= finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_w_q     <= '0;
			chunk_vld_q <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			hold_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				rem_w_q <= q_rdata.width;
				// flush: pad the partial byte out to a full one
				if (q_rdata.kind == CMD_FLUSH && cnt_q != '0) begin
					cnt_q <= BYTE_BITS;
				end
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (gen) begin
				rem_w_q <= rem_w_d;
			end

			if (gen) begin
				chunk_vld_q <= 1'b1;
			end else if (take) begin
				chunk_vld_q <= 1'b0;
			end

			if (emit) begin
				acc_q <= acc_q << 8;
				cnt_q <= cnt_q - BYTE_BITS;
			end else if (take) begin
				acc_q <= merged;
				cnt_q <= cnt_q + chunk_n_q;
			end

			if (emit) begin
				hold_vld_q <= 1'b1;
			end else if (finish) begin
				hold_vld_q <= 1'b0;
			end

			if (push_out) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign results.valid       = out_vld_q;
	assign results.out_byte    = out_byte_q;
	assign results.last_of_run = out_last_q;

endmodule

[sv/msb_first_bit_field_packer.sv]
// Packs fields of 1 to VALUE_WIDTH bits MSB-first into a byte stream, with plain writes,
// segmented variable-length writes (flag bit then segment_size payload bits, low segment
// first, flag clear on the last) and a flush that pads the partial byte with zeros. Each
// item that produces bytes marks its final byte with last_of_run. Items enter a two-deep
// command queue, so the input side keeps moving while the byte engine drains. The engine
// merges one chunk (a whole plain field or one segment) at a time into its accumulator,
// only while less than a byte is pending, and sends out one byte per cycle while the
// output accepts them; it takes the next item from the queue only once the current one
// is done.
// segment_size sits at byte address 0 of the APB port; reset value 7, zero acts as one.
module msb_first_bit_field_packer #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfp_pkg::PADDR_W-1:0]    paddr,
	input  logic [bfp_pkg::PDATA_W-1:0]    pwdata,
	output logic [bfp_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	bfp_in_if.sink                         items,
	bfp_out_if.source                      results
);
	import bfp_pkg::*;

	logic [SEG_W-1:0]     seg_size_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 q_full;
	logic                 q_push;
	cmd_t                 q_wdata;
	logic                 q_pop;
	logic                 q_vld;
	cmd_t                 q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign prdata  = (reg_idx == REG_SEG_SIZE) ? PDATA_W'(seg_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q <= SEG_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_SEG_SIZE) begin
			seg_size_q <= pwdata[SEG_W-1:0];
		end
	end

	bfp_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.items   (items),
		.seg_size(seg_size_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	bfp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.vld   (q_vld),
		.rdata (q_rdata)
	);

	bfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_rdata(q_rdata),
		.q_pop  (q_pop),
		.results(results)
	);

endmodule
